// File: src/z85_codec_assert.svh
// Assertion macros shared by the Z85 codec RTL.
// Each macro expects clk_i and rst_ni to exist in the including module.
`ifndef Z85_CODEC_ASSERT_SVH
`define Z85_CODEC_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define Z85_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define Z85_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: src/z85_pkg.sv
// Shared types, constants and lookup tables of the Z85 codec.
// No dependencies; every other RTL file imports this package.
package z85_pkg;

  // Base of the Z85 number system.
  localparam logic [31:0] RADIX = 32'd85;

  // Items per group on the input side.
  localparam logic [2:0] ENC_GROUP_LEN = 3'd4;
  localparam logic [2:0] DEC_GROUP_LEN = 3'd5;

  // Results per group on the output side.
  localparam logic [2:0] ENC_OUT_LEN = 3'd5;
  localparam logic [2:0] DEC_OUT_LEN = 3'd4;
  localparam logic [2:0] ERR_OUT_LEN = 3'd1;

  // floor(x / 85) == (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT = 38;

  // The encoder divides the word by 85 four times; the last quotient is the top digit.
  localparam logic [2:0] LAST_STEP = 3'd4;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        fend;
    logic [31:0] word;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Digit converter states in the back.
  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_FULL
  } cv_state_e;

  // Digit value to character.
  localparam logic [7:0] Z85_ALPHABET [85] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
    "k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
    "u", "v", "w", "x", "y", "z", "A", "B", "C", "D",
    "E", "F", "G", "H", "I", "J", "K", "L", "M", "N",
    "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X",
    "Y", "Z", ".", "-", ":", "+", "=", "^", "!", "/",
    "*", "?", "&", "<", ">", "(", ")", "[", "]", "{",
    "}", "@", "%", "$", "#"
  };

  // Character minus 32 to digit value; characters outside the alphabet give zero.
  localparam logic [6:0] DIGIT_OF_CHAR [96] = '{
    7'h00, 7'h44, 7'h00, 7'h54, 7'h53, 7'h52, 7'h48, 7'h00,
    7'h4B, 7'h4C, 7'h46, 7'h41, 7'h00, 7'h3F, 7'h3E, 7'h45,
    7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
    7'h08, 7'h09, 7'h40, 7'h00, 7'h49, 7'h42, 7'h4A, 7'h47,
    7'h51, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2A,
    7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h30, 7'h31, 7'h32,
    7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3A,
    7'h3B, 7'h3C, 7'h3D, 7'h4D, 7'h00, 7'h4E, 7'h43, 7'h00,
    7'h00, 7'h0A, 7'h0B, 7'h0C, 7'h0D, 7'h0E, 7'h0F, 7'h10,
    7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18,
    7'h19, 7'h1A, 7'h1B, 7'h1C, 7'h1D, 7'h1E, 7'h1F, 7'h20,
    7'h21, 7'h22, 7'h23, 7'h4F, 7'h00, 7'h50, 7'h00, 7'h00
  };

endpackage

// File: src/z85_front.sv
// Input side of the Z85 codec: direction register, group gathering and job issue.
// Depends on z85_pkg and z85_codec_assert.svh.
`include "z85_codec_assert.svh"

module z85_front import z85_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        direction_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_in_i,
  input  logic        frame_end_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output job_t        job_o
);

  logic        dir_q;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  pos_q, pos_d;

  logic        accept;
  logic        in_range;
  logic [6:0]  chr_idx;
  logic [6:0]  digit;
  logic [2:0]  grp_len;
  logic [2:0]  pos_inc;
  logic [31:0] acc_next;

  // A word is taken whenever the queue has room for a possible job.
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  // Character to digit; anything outside 32..127 is digit zero.
  assign in_range = !data_in_i[7] && (data_in_i[6:5] != 2'b00);
  assign chr_idx  = data_in_i[6:0] - 7'd32;
  assign digit    = in_range ? DIGIT_OF_CHAR[chr_idx] : 7'd0;

  assign grp_len = dir_q ? DEC_GROUP_LEN : ENC_GROUP_LEN;
  assign pos_inc = pos_q + 3'd1;

  // Encode shifts a byte in; decode multiplies by 85 and adds the digit.
  assign acc_next = dir_q ? (acc_q * RADIX + {25'd0, digit}) : {acc_q[23:0], data_in_i};

  // Group tracking and job issue.
  always_comb begin
    acc_d     = acc_q;
    pos_d     = pos_q;
    push_o    = 1'b0;
    job_o     = '{kind: JOB_ERR, fend: frame_end_i, word: acc_next};
    if (cfg_we_i) begin
      acc_d = '0;
      pos_d = '0;
    end else if (accept) begin
      if (pos_inc == grp_len) begin
        push_o     = 1'b1;
        job_o.kind = dir_q ? JOB_DEC : JOB_ENC;
        acc_d      = '0;
        pos_d      = '0;
      end else if (frame_end_i) begin
        push_o     = 1'b1;
        job_o.kind = JOB_ERR;
        job_o.word = '0;
        acc_d      = '0;
        pos_d      = '0;
      end else begin
        acc_d = acc_next;
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= direction_i;
      end
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

  // The gathered count never reaches a full group without being issued.
  `Z85_ASSERT(a_pos_in_group, pos_q < grp_len, "front group position out of range")

endmodule

// File: src/z85_fifo.sv
// Short job queue between the front and the back of the Z85 codec.
// Depends on z85_pkg and z85_codec_assert.svh.
`include "z85_codec_assert.svh"

module z85_fifo import z85_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        job_i,
  input  logic        pop_i,
  output job_t        job_o,
  output queue_stat_t stat_o
);

  job_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_PTR_W:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (Q_PTR_W + 1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (Q_PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (Q_PTR_W + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `Z85_ASSERT_NEVER(a_push_full, push_i && stat_o.full, "job pushed into a full queue")
  `Z85_ASSERT_NEVER(a_pop_empty, pop_i && stat_o.empty, "job popped from an empty queue")

endmodule

// File: src/z85_back.sv
// Output side of the Z85 codec: digit converter, symbol buffer and output register.
// Depends on z85_pkg and z85_codec_assert.svh.
`include "z85_codec_assert.svh"

module z85_back import z85_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_stat_t q_stat_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_out_o,
  output logic        group_last_o,
  output logic        frame_last_o,
  output logic        error_o
);

  // Converter state.
  cv_state_e   cv_state_q, cv_state_d;
  logic [2:0]  cv_step_q;
  job_kind_e   kind_q;
  logic        fend_q;
  logic [31:0] val_q;
  logic [6:0]  prev_q;
  logic [6:0]  dig_q [4];

  logic        load_job;
  logic        handoff;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [6:0]  rem;

  // Symbol buffer and output register.
  logic [7:0]  em_sym_q [5];
  logic [2:0]  em_left_q;
  logic        em_fend_q;
  logic        em_err_q;
  logic        adv;
  logic        em_take;
  logic        em_free;
  logic [7:0]  load_sym [5];
  logic [2:0]  load_left;

  logic        out_valid_q;
  logic [7:0]  data_q;
  logic        glast_q;
  logic        flast_q;
  logic        err_q;

  // One division by 85 per step through the reciprocal; the remainder needs only 7 bits.
  assign prod = {32'd0, val_q} * {32'd0, RECIP_85};
  assign quot = 32'(prod >> RECIP_SHIFT);
  assign rem  = prev_q - val_q[6:0] * RADIX[6:0];

  // Output register moves when empty or when the word is taken.
  assign adv     = !out_valid_q || !out_stall_i;
  assign em_take = (em_left_q != 3'd0) && adv;
  assign em_free = (em_left_q == 3'd0) || ((em_left_q == 3'd1) && adv);

  // Converter sequencing.
  always_comb begin
    cv_state_d = cv_state_q;
    pop_o      = 1'b0;
    load_job   = 1'b0;
    handoff    = 1'b0;
    unique case (cv_state_q)
      CV_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o      = 1'b1;
          load_job   = 1'b1;
          cv_state_d = (job_i.kind == JOB_ENC) ? CV_RUN : CV_FULL;
        end
      end
      CV_RUN: begin
        if (cv_step_q == LAST_STEP) begin
          cv_state_d = CV_FULL;
        end
      end
      CV_FULL: begin
        if (em_free) begin
          handoff = 1'b1;
          if (!q_stat_i.empty) begin
            pop_o      = 1'b1;
            load_job   = 1'b1;
            cv_state_d = (job_i.kind == JOB_ENC) ? CV_RUN : CV_FULL;
          end else begin
            cv_state_d = CV_IDLE;
          end
        end
      end
      default: cv_state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_state_q <= CV_IDLE;
      cv_step_q  <= '0;
    end else begin
      cv_state_q <= cv_state_d;
      if (load_job) begin
        cv_step_q <= '0;
      end else if (cv_state_q == CV_RUN) begin
        cv_step_q <= cv_step_q + 3'd1;
      end
    end
  end

  // Converter datapath: digits come out least significant first.
  always_ff @(posedge clk_i) begin
    if (load_job) begin
      val_q  <= job_i.word;
      kind_q <= job_i.kind;
      fend_q <= job_i.fend;
    end else if (cv_state_q == CV_RUN) begin
      prev_q <= val_q[6:0];
      if (cv_step_q != LAST_STEP) begin
        val_q <= quot;
      end
      if (cv_step_q != 3'd0) begin
        for (int i = 0; i < 3; i++) begin
          dig_q[i] <= dig_q[i+1];
        end
        dig_q[3] <= rem;
      end
    end
  end

  // Symbols of the finished job in the order they leave.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      load_sym[i] = 8'd0;
    end
    load_left = 3'd0;
    unique case (kind_q)
      JOB_ENC: begin
        load_sym[0] = Z85_ALPHABET[val_q[6:0]];
        load_sym[1] = Z85_ALPHABET[dig_q[3]];
        load_sym[2] = Z85_ALPHABET[dig_q[2]];
        load_sym[3] = Z85_ALPHABET[dig_q[1]];
        load_sym[4] = Z85_ALPHABET[dig_q[0]];
        load_left   = ENC_OUT_LEN;
      end
      JOB_DEC: begin
        load_sym[0] = val_q[31:24];
        load_sym[1] = val_q[23:16];
        load_sym[2] = val_q[15:8];
        load_sym[3] = val_q[7:0];
        load_left   = DEC_OUT_LEN;
      end
      JOB_ERR: begin
        load_left = ERR_OUT_LEN;
      end
      default: load_left = 3'd0;
    endcase
  end

  // Control of the symbol buffer and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= (em_left_q != 3'd0);
      end
      if (handoff) begin
        em_left_q <= load_left;
      end else if (em_take) begin
        em_left_q <= em_left_q - 3'd1;
      end
    end
  end

  // Symbol buffer shifts one toward the output each time a word leaves.
  always_ff @(posedge clk_i) begin
    if (em_take) begin
      data_q  <= em_sym_q[0];
      glast_q <= (em_left_q == 3'd1) && !em_err_q;
      flast_q <= (em_left_q == 3'd1) && em_fend_q;
      err_q   <= em_err_q;
    end
    if (handoff) begin
      em_sym_q  <= load_sym;
      em_fend_q <= fend_q;
      em_err_q  <= (kind_q == JOB_ERR);
    end else if (em_take) begin
      for (int i = 0; i < 4; i++) begin
        em_sym_q[i] <= em_sym_q[i+1];
      end
      em_sym_q[4] <= 8'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = data_q;
  assign group_last_o = glast_q;
  assign frame_last_o = flast_q;
  assign error_o      = err_q;

  // An error word is a lone zero that closes the frame.
  `Z85_ASSERT(a_err_word, (out_valid_o && error_o) |-> (frame_last_o && !group_last_o && data_out_o == 8'd0), "malformed error word")
  // After four divisions the remaining quotient is the top digit.
  `Z85_ASSERT(a_top_digit, (cv_state_q == CV_FULL && kind_q == JOB_ENC) |-> (val_q < RADIX), "top digit out of range")

endmodule

// File: src/z85_codec.sv
// Z85 codec: each group passes from the front through the job queue and the converter
// to the symbol buffer and the output register; encoding adds the divide-by-85 steps.
// The input takes one word per cycle while the two-entry job queue has room. Encoding
// converts one group at a time by dividing by 85; output is one per cycle unless stalled.
// Asynchronous active-low reset clears direction, the partial group, queue and output valid.
module z85_codec import z85_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       direction_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_in_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o,
  output logic       group_last_o,
  output logic       frame_last_o,
  output logic       error_o
);

  queue_stat_t q_stat;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        pop_job;

  // Gathers groups and issues jobs.
  z85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .direction_i (direction_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_in_i   (data_in_i),
    .frame_end_i (frame_end_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouples the front from the back.
  z85_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  // Converts jobs and drives the output words.
  z85_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .group_last_o (group_last_o),
    .frame_last_o (frame_last_o),
    .error_o      (error_o)
  );

endmodule
